// ----- hdl/mtk_pkg.sv -----
package mtk_pkg;

    // Event opcodes
    typedef enum logic [2:0] {
        OP_KEY   = 3'd0,
        OP_TICK  = 3'd1,
        OP_BKSP  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_MODE  = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    // Entry modes
    localparam logic [1:0] MODE_LOWER  = 2'd0;
    localparam logic [1:0] MODE_UPPER  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // Character constants
    localparam logic [7:0] KEY_0        = 8'h30;
    localparam logic [7:0] KEY_9        = 8'h39;
    localparam logic [7:0] LOWER_A      = 8'h61;
    localparam logic [7:0] LOWER_Z      = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] UTF8_LEAD    = 8'hC3;
    localparam logic [7:0] ACCENT_LO    = 8'hA0;
    localparam logic [7:0] ACCENT_HI    = 8'hBE;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WR,
        ST_SCAN,
        ST_RDATA,
        ST_FINISH
    } st_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] key_code;
        logic [31:0] now_ms;
        logic [7:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [8:0]  text_length;
        logic        pending_valid;
        logic [1:0]  candidate_len;
        logic [7:0]  candidate_first;
        logic [7:0]  candidate_second;
        logic [1:0]  entry_mode;
        logic [7:0]  read_data;
    } out_item_t;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
    } cand_t;

    // Number of glyphs on each key
    function automatic logic [3:0] glyph_count(input logic [3:0] d);
        logic [3:0] n;
        begin
            unique case (d)
                4'd0:    n = 4'd2;
                4'd1:    n = 4'd11;
                4'd2:    n = 4'd5;
                4'd3:    n = 4'd6;
                4'd4:    n = 4'd5;
                4'd5:    n = 4'd4;
                4'd6:    n = 4'd5;
                4'd7:    n = 4'd5;
                4'd8:    n = 4'd5;
                4'd9:    n = 4'd5;
                default: n = 4'd1;
            endcase
            return n;
        end
    endfunction

    // Glyph bytes {first, second} for key d at position p
    function automatic logic [15:0] glyph_lookup(input logic [3:0] d, input logic [3:0] p);
        logic [15:0] g;
        begin
            g = 16'h0000;
            unique case (d)
                4'd0: begin
                    case (p)
                        4'd0:    g = 16'h2000;
                        4'd1:    g = 16'h3000;
                        default: g = 16'h0000;
                    endcase
                end
                4'd1: begin
                    case (p)
                        4'd0:    g = 16'h2E00;
                        4'd1:    g = 16'h2C00;
                        4'd2:    g = 16'h3F00;
                        4'd3:    g = 16'h2100;
                        4'd4:    g = 16'h2700;
                        4'd5:    g = 16'h2200;
                        4'd6:    g = 16'h2D00;
                        4'd7:    g = 16'h4000;
                        4'd8:    g = 16'h2F00;
                        4'd9:    g = 16'h3A00;
                        4'd10:   g = 16'h3100;
                        default: g = 16'h0000;
                    endcase
                end
                4'd2: begin
                    case (p)
                        4'd0:    g = 16'h6100;
                        4'd1:    g = 16'h6200;
                        4'd2:    g = 16'h6300;
                        4'd3:    g = 16'h3200;
                        4'd4:    g = 16'hC3A0;
                        default: g = 16'h0000;
                    endcase
                end
                4'd3: begin
                    case (p)
                        4'd0:    g = 16'h6400;
                        4'd1:    g = 16'h6500;
                        4'd2:    g = 16'h6600;
                        4'd3:    g = 16'h3300;
                        4'd4:    g = 16'hC3A8;
                        4'd5:    g = 16'hC3A9;
                        default: g = 16'h0000;
                    endcase
                end
                4'd4: begin
                    case (p)
                        4'd0:    g = 16'h6700;
                        4'd1:    g = 16'h6800;
                        4'd2:    g = 16'h6900;
                        4'd3:    g = 16'h3400;
                        4'd4:    g = 16'hC3AC;
                        default: g = 16'h0000;
                    endcase
                end
                4'd5: begin
                    case (p)
                        4'd0:    g = 16'h6A00;
                        4'd1:    g = 16'h6B00;
                        4'd2:    g = 16'h6C00;
                        4'd3:    g = 16'h3500;
                        default: g = 16'h0000;
                    endcase
                end
                4'd6: begin
                    case (p)
                        4'd0:    g = 16'h6D00;
                        4'd1:    g = 16'h6E00;
                        4'd2:    g = 16'h6F00;
                        4'd3:    g = 16'h3600;
                        4'd4:    g = 16'hC3B2;
                        default: g = 16'h0000;
                    endcase
                end
                4'd7: begin
                    case (p)
                        4'd0:    g = 16'h7000;
                        4'd1:    g = 16'h7100;
                        4'd2:    g = 16'h7200;
                        4'd3:    g = 16'h7300;
                        4'd4:    g = 16'h3700;
                        default: g = 16'h0000;
                    endcase
                end
                4'd8: begin
                    case (p)
                        4'd0:    g = 16'h7400;
                        4'd1:    g = 16'h7500;
                        4'd2:    g = 16'h7600;
                        4'd3:    g = 16'h3800;
                        4'd4:    g = 16'hC3B9;
                        default: g = 16'h0000;
                    endcase
                end
                4'd9: begin
                    case (p)
                        4'd0:    g = 16'h7700;
                        4'd1:    g = 16'h7800;
                        4'd2:    g = 16'h7900;
                        4'd3:    g = 16'h7A00;
                        4'd4:    g = 16'h3900;
                        default: g = 16'h0000;
                    endcase
                end
                default: g = 16'h0000;
            endcase
            return g;
        end
    endfunction

    // Pending glyph after case mapping; all zero when nothing is pending
    function automatic cand_t cand_map(input logic pend, input logic [3:0] d,
                                       input logic [3:0] p, input logic [1:0] mode);
        cand_t       c;
        logic [15:0] g;
        begin
            g = glyph_lookup(d, p);
            c.b0 = g[15:8];
            c.b1 = g[7:0];
            if (mode == MODE_UPPER) begin
                if (c.b1 == 8'h00) begin
                    if (c.b0 >= LOWER_A && c.b0 <= LOWER_Z) begin
                        c.b0 = c.b0 - CASE_OFFSET;
                    end
                end else if (c.b0 == UTF8_LEAD && c.b1 >= ACCENT_LO && c.b1 <= ACCENT_HI) begin
                    c.b1 = c.b1 - CASE_OFFSET;
                end
            end
            c.len = (c.b1 == 8'h00) ? 2'd1 : 2'd2;
            if (!pend) begin
                c = '0;
            end
            return c;
        end
    endfunction

endpackage

// ----- hdl/mtk_ram.sv -----
module mtk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/multitap_keypad_text_entry_top.sv -----
// Multi-tap keypad text entry.
//
// Input channel (in_valid / in_stall / in_data): one event per beat - key
// press, tick, backspace, clear, mode cycle or buffer read. Output channel
// (out_valid / out_stall / out_data): exactly one result beat per event,
// showing the state after the event. Configuration (cfg_valid / cfg_ready /
// cfg_data) writes the tap timeout while no event is in flight.
//
// Sequencing: an accepted event passes through EXEC and then FINISH,
// where the result register loads; the next event is taken once the
// sequencer is back in IDLE. A commit of one byte adds no state, a read
// adds RDATA, and a two-byte commit or a number-mode digit each add a
// write step in WR. Backspace adds a SCAN step per byte it reads back
// from the buffer tail. The single write port and the registered read of
// the text memory set these steps; one event is in flight at a time.
//
// Reset clears the length, the pending glyph, the mode (lower), the last
// press time and sets the timeout to 1000 ms; the text memory is not
// cleared. When the receiver stalls, the finished result holds in the output
// register; the next event is still taken and waits at the end of its work.
module multitap_keypad_text_entry_top
    import mtk_pkg::*;
#(
    parameter int TEXT_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(TEXT_BYTES);
    localparam int LW = $clog2(TEXT_BYTES + 1);
    localparam logic [LW:0] DEPTH_C = (LW + 1)'(TEXT_BYTES);

    // Sequencer and captured event
    st_t             state_reg, state_next;
    in_item_t        ev_reg, ev_next;

    // Architectural state
    logic [LW-1:0]   len_reg, len_next;
    logic            pend_reg, pend_next;
    logic [3:0]      pdig_reg, pdig_next;
    logic [3:0]      ppos_reg, ppos_next;
    logic [31:0]     last_reg, last_next;
    logic [1:0]      mode_reg, mode_next;
    logic [31:0]     tmo_reg, tmo_next;

    // Per-event work registers
    logic            acc_reg, acc_next;
    logic [7:0]      rdata_reg, rdata_next;
    logic            sec_reg, sec_next;
    logic [7:0]      sec_byte_reg, sec_byte_next;
    logic [AW-1:0]   sec_addr_reg, sec_addr_next;
    logic            keywr_reg, keywr_next;
    logic [AW-1:0]   cut_reg, cut_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    // Text memory port
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    cand_t           cand;
    logic            fits;
    logic [31:0]     elapsed;
    logic            key_ok;
    logic [3:0]      key_dig;
    logic            cycle_hit;
    logic [LW+7:0]   ridx_cmp;
    logic [LW+7:0]   len_cmp;
    logic [AW+7:0]   ridx_ext;
    logic [LW+8:0]   len_out;
    logic [3:0]      pos_inc;

    mtk_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_BYTES)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Candidate glyph and event decode helpers
    assign cand      = cand_map(pend_reg, pdig_reg, ppos_reg, mode_reg);
    assign fits      = ({1'b0, len_reg} + {{(LW - 1){1'b0}}, cand.len}) <= DEPTH_C;
    assign elapsed   = ev_reg.now_ms - last_reg;
    assign key_ok    = (ev_reg.key_code >= KEY_0) && (ev_reg.key_code <= KEY_9);
    assign key_dig   = ev_reg.key_code[3:0];
    assign cycle_hit = pend_reg && (pdig_reg == key_dig) && (elapsed < tmo_reg);
    assign ridx_cmp  = {{LW{1'b0}}, ev_reg.read_index};
    assign len_cmp   = {8'h00, len_reg};
    assign ridx_ext  = {{AW{1'b0}}, ev_reg.read_index};
    assign len_out   = {9'h000, len_reg};
    assign pos_inc   = ppos_reg + 4'd1;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            pdig_reg      <= 4'd0;
            ppos_reg      <= 4'd0;
            last_reg      <= 32'd0;
            mode_reg      <= MODE_LOWER;
            tmo_reg       <= 32'd1000;
            sec_reg       <= 1'b0;
            keywr_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            pdig_reg      <= pdig_next;
            ppos_reg      <= ppos_next;
            last_reg      <= last_next;
            mode_reg      <= mode_next;
            tmo_reg       <= tmo_next;
            sec_reg       <= sec_next;
            keywr_reg     <= keywr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ev_reg       <= ev_next;
        acc_reg      <= acc_next;
        rdata_reg    <= rdata_next;
        sec_byte_reg <= sec_byte_next;
        sec_addr_reg <= sec_addr_next;
        cut_reg      <= cut_next;
        out_data_reg <= out_data_next;
    end

    // Next state and memory control
    always_comb
    begin
        logic do_commit;
        logic do_scan;
        logic do_read;
        logic [AW-1:0] cut_dec;

        state_next     = state_reg;
        ev_next        = ev_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        pdig_next      = pdig_reg;
        ppos_next      = ppos_reg;
        last_next      = last_reg;
        mode_next      = mode_reg;
        tmo_next       = tmo_reg;
        acc_next       = acc_reg;
        rdata_next     = rdata_reg;
        sec_next       = sec_reg;
        sec_byte_next  = sec_byte_reg;
        sec_addr_next  = sec_addr_reg;
        keywr_next     = keywr_reg;
        cut_next       = cut_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = len_reg[AW-1:0];
        ram_wdata      = cand.b0;
        ram_re         = 1'b0;
        ram_raddr      = cut_reg;
        do_commit      = 1'b0;
        do_scan        = 1'b0;
        do_read        = 1'b0;
        cut_dec        = cut_reg - 1'b1;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    tmo_next = cfg_data;
                end
                if (in_valid)
                begin
                    ev_next    = in_data;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                acc_next   = 1'b0;
                rdata_next = 8'h00;

                // Decide which events commit the pending glyph
                unique case (ev_reg.opcode)
                    OP_KEY:   do_commit = key_ok && ((mode_reg == MODE_NUMBER) || !cycle_hit);
                    OP_TICK:  do_commit = pend_reg && (elapsed >= tmo_reg);
                    OP_MODE:  do_commit = 1'b1;
                    default:  do_commit = 1'b0;
                endcase

                // Commit: first byte now, second byte in the write state
                if (do_commit && pend_reg)
                begin
                    pend_next = 1'b0;
                    pdig_next = 4'd0;
                    ppos_next = 4'd0;
                    if (fits)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = len_reg[AW-1:0];
                        ram_wdata = cand.b0;
                        len_next  = len_reg + LW'(cand.len);
                        if (cand.len == 2'd2)
                        begin
                            sec_next      = 1'b1;
                            sec_byte_next = cand.b1;
                            sec_addr_next = len_reg[AW-1:0] + 1'b1;
                        end
                    end
                end

                unique case (ev_reg.opcode)
                    OP_KEY:
                    begin
                        if (key_ok)
                        begin
                            acc_next = 1'b1;
                            if (mode_reg == MODE_NUMBER)
                            begin
                                keywr_next = 1'b1;
                            end
                            else
                            begin
                                if (cycle_hit)
                                begin
                                    ppos_next = (pos_inc == glyph_count(key_dig)) ? 4'd0 : pos_inc;
                                end
                                else
                                begin
                                    pend_next = 1'b1;
                                    pdig_next = key_dig;
                                    ppos_next = 4'd0;
                                end
                                last_next = ev_reg.now_ms;
                            end
                        end
                    end

                    OP_TICK:
                    begin
                        acc_next = do_commit;
                    end

                    OP_BKSP:
                    begin
                        if (pend_reg)
                        begin
                            pend_next = 1'b0;
                            pdig_next = 4'd0;
                            ppos_next = 4'd0;
                            acc_next  = 1'b1;
                        end
                        else if (len_reg != '0)
                        begin
                            acc_next = 1'b1;
                            cut_next = len_reg[AW-1:0] - 1'b1;
                            if (cut_next == '0)
                            begin
                                len_next = '0;
                            end
                            else
                            begin
                                // Fetch the tail byte
                                ram_re    = 1'b1;
                                ram_raddr = cut_next;
                                do_scan   = 1'b1;
                            end
                        end
                    end

                    OP_CLEAR:
                    begin
                        pend_next = 1'b0;
                        pdig_next = 4'd0;
                        ppos_next = 4'd0;
                        len_next  = '0;
                        acc_next  = 1'b1;
                    end

                    OP_MODE:
                    begin
                        unique case (mode_reg)
                            MODE_LOWER: mode_next = MODE_UPPER;
                            MODE_UPPER: mode_next = MODE_NUMBER;
                            default:    mode_next = MODE_LOWER;
                        endcase
                        acc_next = 1'b1;
                    end

                    OP_READ:
                    begin
                        if (ridx_cmp < len_cmp)
                        begin
                            acc_next  = 1'b1;
                            ram_re    = 1'b1;
                            ram_raddr = ridx_ext[AW-1:0];
                            do_read   = 1'b1;
                        end
                    end

                    default:
                    begin
                        acc_next = 1'b0;
                    end
                endcase

                if (sec_next || keywr_next)
                begin
                    state_next = ST_WR;
                end
                else if (do_scan)
                begin
                    state_next = ST_SCAN;
                end
                else if (do_read)
                begin
                    state_next = ST_RDATA;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_WR:
            begin
                if (sec_reg)
                begin
                    // Second byte of an accented glyph
                    ram_we    = 1'b1;
                    ram_waddr = sec_addr_reg;
                    ram_wdata = sec_byte_reg;
                    sec_next  = 1'b0;
                    if (!keywr_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    // Append the digit in number mode when there is room
                    keywr_next = 1'b0;
                    if ({1'b0, len_reg} < DEPTH_C)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = len_reg[AW-1:0];
                        ram_wdata = ev_reg.key_code;
                        len_next  = len_reg + 1'b1;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_SCAN:
            begin
                // Walk back over continuation bytes
                if ((ram_rdata & CONT_MASK) == CONT_TAG)
                begin
                    cut_next = cut_dec;
                    if (cut_dec == '0)
                    begin
                        len_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cut_dec;
                    end
                end
                else
                begin
                    len_next   = LW'(cut_reg);
                    state_next = ST_FINISH;
                end
            end

            ST_RDATA:
            begin
                rdata_next = ram_rdata;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.accepted         = acc_reg;
                    out_data_next.text_length      = len_out[8:0];
                    out_data_next.pending_valid    = pend_reg;
                    out_data_next.candidate_len    = cand.len;
                    out_data_next.candidate_first  = cand.b0;
                    out_data_next.candidate_second = cand.b1;
                    out_data_next.entry_mode       = mode_reg;
                    out_data_next.read_data        = rdata_reg;
                    state_next                     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Buffer length never passes the memory depth
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, len_reg} <= DEPTH_C)
    else $error("text length beyond buffer depth");

    // A pending glyph always belongs to a digit key and has bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pdig_reg <= 4'd9) && (cand.len != 2'd0))
    else $error("pending glyph malformed");

    // Memory writes only while executing or writing back
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EXEC) || (state_reg == ST_WR))
    else $error("memory write outside write states");

    // An accepted event starts execution next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_EXEC))
    else $error("accepted event did not start");

    // A result is loaded only when the sequencer finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || !out_stall) && (state_reg != ST_FINISH) |=> !out_valid_reg)
    else $error("result loaded outside finish");

endmodule

// ----- dv/multitap_keypad_text_entry_top_test.sv -----
`timescale 1ns / 1ps

module multitap_keypad_text_entry_top_test;
    import mtk_pkg::*;

    localparam int TEXT_BYTES = 256;
    localparam int CLK_HALF_NS = 4;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS = 325;
    localparam int IDLE_PERCENT = 22;
    localparam longint WATCHDOG_NS = 4_000_000;

    // Opcodes the block ignores
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Key sequences as {first byte, second byte}, padded to the longest key
    localparam logic [15:0] KEY_GLYPHS [10][11] = '{
        '{16'h2000, 16'h3000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h2E00, 16'h2C00, 16'h3F00, 16'h2100, 16'h2700, 16'h2200,
          16'h2D00, 16'h4000, 16'h2F00, 16'h3A00, 16'h3100},
        '{16'h6100, 16'h6200, 16'h6300, 16'h3200, 16'hC3A0, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h6400, 16'h6500, 16'h6600, 16'h3300, 16'hC3A8, 16'hC3A9,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h6700, 16'h6800, 16'h6900, 16'h3400, 16'hC3AC, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h6A00, 16'h6B00, 16'h6C00, 16'h3500, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h6D00, 16'h6E00, 16'h6F00, 16'h3600, 16'hC3B2, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7000, 16'h7100, 16'h7200, 16'h7300, 16'h3700, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7400, 16'h7500, 16'h7600, 16'h3800, 16'hC3B9, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7700, 16'h7800, 16'h7900, 16'h7A00, 16'h3900, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}
    };
    localparam int KEY_GLYPH_COUNT [10] = '{2, 11, 5, 6, 5, 4, 5, 5, 5, 5};

    typedef struct packed {
        in_item_t  ev;
        bit        has_fixed;
        out_item_t fixed_result;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // Shadow of the block's state
    logic [7:0]  text_mem [TEXT_BYTES];
    int          text_len = 0;
    logic        pend_on = 1'b0;
    logic [3:0]  pend_digit = '0;
    logic [3:0]  pend_pos = '0;
    logic [31:0] last_press = '0;
    logic [1:0]  cur_mode = MODE_LOWER;
    logic [31:0] tap_timeout = 32'd1000;

    out_item_t     expected_results [$];
    out_item_t     want_result;
    directed_row_t directed_rows [$];
    int            error_count = 0;
    int            sent_events = 0;
    bit            no_idle = 1'b0;
    logic [31:0]   wall_ms = '0;

    multitap_keypad_text_entry_top #(
        .TEXT_BYTES(TEXT_BYTES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    function automatic bit idle_hit();
        if (no_idle)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_item_t make_event(input logic [2:0] op, input logic [7:0] key,
                                            input logic [31:0] at, input logic [7:0] idx);
        in_item_t ev;
        ev.opcode = op;
        ev.key_code = key;
        ev.now_ms = at;
        ev.read_index = idx;
        return ev;
    endfunction

    function automatic out_item_t make_result(input logic acc, input logic [8:0] len,
                                              input logic pend, input logic [1:0] clen,
                                              input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [1:0] mode, input logic [7:0] rd);
        out_item_t r;
        r.accepted = acc;
        r.text_length = len;
        r.pending_valid = pend;
        r.candidate_len = clen;
        r.candidate_first = b0;
        r.candidate_second = b1;
        r.entry_mode = mode;
        r.read_data = rd;
        return r;
    endfunction

    // Pending glyph with the current case applied; zero when nothing waits
    function automatic cand_t pending_glyph();
        cand_t       c;
        logic [15:0] g;
        c = '0;
        if (pend_on)
        begin
            g = KEY_GLYPHS[pend_digit][pend_pos % KEY_GLYPH_COUNT[pend_digit]];
            c.b0 = g[15:8];
            c.b1 = g[7:0];
            if (cur_mode == MODE_UPPER)
            begin
                if (c.b1 == 8'h00)
                begin
                    if (c.b0 >= LOWER_A && c.b0 <= LOWER_Z)
                        c.b0 = c.b0 - CASE_OFFSET;
                end
                else if (c.b0 == UTF8_LEAD && c.b1 >= ACCENT_LO && c.b1 <= ACCENT_HI)
                    c.b1 = c.b1 - CASE_OFFSET;
            end
            c.len = (c.b1 == 8'h00) ? 2'd1 : 2'd2;
        end
        return c;
    endfunction

    // Move the pending glyph into the text; drop it when it does not fit
    function automatic void commit_pending();
        cand_t c;
        if (!pend_on)
            return;
        c = pending_glyph();
        pend_on = 1'b0;
        pend_digit = '0;
        pend_pos = '0;
        if (text_len + c.len <= TEXT_BYTES)
        begin
            text_mem[text_len] = c.b0;
            if (c.len == 2'd2)
                text_mem[text_len + 1] = c.b1;
            text_len = text_len + c.len;
        end
    endfunction

    // Advance the shadow state by one event and form the result it causes
    function automatic out_item_t apply_event(input in_item_t ev);
        out_item_t   r;
        cand_t       c;
        int          cut;
        logic [7:0]  offset;
        logic [3:0]  d;
        logic [31:0] gap;
        r = '0;
        case (ev.opcode)
            OP_KEY:
            begin
                if (ev.key_code >= KEY_0 && ev.key_code <= KEY_9)
                begin
                    offset = ev.key_code - KEY_0;
                    d = offset[3:0];
                    gap = ev.now_ms - last_press;
                    r.accepted = 1'b1;
                    if (cur_mode == MODE_NUMBER)
                    begin
                        commit_pending();
                        if (text_len < TEXT_BYTES)
                        begin
                            text_mem[text_len] = ev.key_code;
                            text_len++;
                        end
                    end
                    else
                    begin
                        if (pend_on && pend_digit == d && gap < tap_timeout)
                            pend_pos = 4'((pend_pos + 1) % KEY_GLYPH_COUNT[d]);
                        else
                        begin
                            commit_pending();
                            pend_on = 1'b1;
                            pend_digit = d;
                            pend_pos = '0;
                        end
                        last_press = ev.now_ms;
                    end
                end
            end
            OP_TICK:
            begin
                gap = ev.now_ms - last_press;
                if (pend_on && gap >= tap_timeout)
                begin
                    commit_pending();
                    r.accepted = 1'b1;
                end
            end
            OP_BKSP:
            begin
                if (pend_on)
                begin
                    pend_on = 1'b0;
                    pend_digit = '0;
                    pend_pos = '0;
                    r.accepted = 1'b1;
                end
                else if (text_len > 0)
                begin
                    // back over continuation bytes to the glyph's lead byte
                    cut = text_len - 1;
                    while (cut > 0 && (text_mem[cut] & CONT_MASK) == CONT_TAG)
                        cut--;
                    text_len = cut;
                    r.accepted = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                pend_on = 1'b0;
                pend_digit = '0;
                pend_pos = '0;
                text_len = 0;
                r.accepted = 1'b1;
            end
            OP_MODE:
            begin
                commit_pending();
                if (cur_mode == MODE_LOWER)
                    cur_mode = MODE_UPPER;
                else if (cur_mode == MODE_UPPER)
                    cur_mode = MODE_NUMBER;
                else
                    cur_mode = MODE_LOWER;
                r.accepted = 1'b1;
            end
            OP_READ:
            begin
                if (ev.read_index < text_len)
                begin
                    r.read_data = text_mem[ev.read_index];
                    r.accepted = 1'b1;
                end
            end
            default:
                r.accepted = 1'b0;
        endcase
        c = pending_glyph();
        r.text_length = text_len[8:0];
        r.pending_valid = pend_on;
        r.candidate_len = c.len;
        r.candidate_first = c.b0;
        r.candidate_second = c.b1;
        r.entry_mode = cur_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Offer one event beat, hold it through stalls, record what it must produce
    task automatic send_event(input in_item_t ev, input bit has_fixed = 1'b0,
                              input out_item_t fixed_result = '0);
        out_item_t predicted;
        while (idle_hit())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= ev;
        do @(posedge clk); while (in_stall);
        predicted = apply_event(ev);
        sent_events++;
        expected_results.push_back(has_fixed ? fixed_result : predicted);
    endtask

    // Hold off the sender until every result beat is back and the block is quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tap_timeout = value;
    endtask

    // Gap between taps: mostly inside the timeout, some on its edges
    function automatic logic [31:0] tap_gap();
        int unsigned pick;
        logic [31:0] limit;
        pick = $urandom_range(0, 99);
        limit = tap_timeout - 32'd1;
        if (pick < 80)
            return (tap_timeout == 0) ? 32'd0 : $urandom_range(0, (limit > 1500) ? 1500 : limit);
        if (pick < 88)
            return limit;
        if (pick < 94)
            return tap_timeout;
        return $urandom;
    endfunction

    // Gap before a tick: mostly enough to let the glyph time out
    function automatic logic [31:0] commit_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return tap_timeout + $urandom_range(0, 2000);
        if (pick < 80)
            return tap_timeout;
        if (pick < 90)
            return tap_timeout - 32'd1;
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_read_index();
        if (text_len > 0 && $urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, text_len - 1));
        return rand_byte();
    endfunction

    // Multi-tap words: runs of taps on one key, closed by a new key or a tick
    task automatic type_word();
        int         taps;
        logic [3:0] d;
        if (cur_mode == MODE_NUMBER && $urandom_range(0, 3) != 0)
            send_event(make_event(OP_MODE, rand_byte(), wall_ms, rand_byte()));
        repeat ($urandom_range(1, 8))
        begin
            d = 4'($urandom_range(0, 9));
            taps = $urandom_range(1, KEY_GLYPH_COUNT[d] + 1);
            repeat (taps)
            begin
                wall_ms = wall_ms + tap_gap();
                send_event(make_event(OP_KEY, KEY_0 + d, wall_ms, rand_byte()));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                wall_ms = wall_ms + commit_gap();
                send_event(make_event(OP_TICK, rand_byte(), wall_ms, rand_byte()));
            end
        end
    endtask

    // Digit bursts in number mode, which also fill the buffer to the top
    task automatic type_digits();
        while (cur_mode != MODE_NUMBER)
            send_event(make_event(OP_MODE, rand_byte(), wall_ms, rand_byte()));
        repeat ($urandom_range(5, 40))
        begin
            wall_ms = wall_ms + $urandom_range(0, 3000);
            send_event(make_event(OP_KEY, KEY_0 + 8'($urandom_range(0, 9)), wall_ms,
                                  rand_byte()));
        end
    endtask

    // Edits and read-back: backspace, byte reads, mode changes
    task automatic edit_text();
        int unsigned pick;
        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(0, 9);
            wall_ms = wall_ms + $urandom_range(0, 500);
            if (pick < 4)
                send_event(make_event(OP_BKSP, rand_byte(), wall_ms, rand_byte()));
            else if (pick < 8)
                send_event(make_event(OP_READ, rand_byte(), wall_ms, pick_read_index()));
            else
                send_event(make_event(OP_MODE, rand_byte(), wall_ms, rand_byte()));
        end
    endtask

    task automatic type_for(input int count);
        int          target;
        int unsigned pick;
        target = sent_events + count;
        while (sent_events < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                type_word();
            else if (pick < 70)
                type_digits();
            else if (pick < 80)
                edit_text();
            else if (pick < 98)
            begin
                // noise: any opcode, any field values
                repeat ($urandom_range(1, 6))
                    send_event(make_event(3'($urandom_range(0, 7)), rand_byte(),
                                          $urandom, rand_byte()));
            end
            else
                send_event(make_event(OP_CLEAR, rand_byte(), wall_ms, rand_byte()));
        end
    endtask

    // Receiver stalls at random
    always @(posedge clk)
        out_stall <= idle_hit();

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result beat with nothing expected", out_data[31:0], 32'd0);
            else
            begin
                want_result = expected_results.pop_front();
                if (out_data.accepted !== want_result.accepted)
                    report_mismatch("accepted", out_data.accepted, want_result.accepted);
                if (out_data.text_length !== want_result.text_length)
                    report_mismatch("text_length", out_data.text_length,
                                    want_result.text_length);
                if (out_data.pending_valid !== want_result.pending_valid)
                    report_mismatch("pending_valid", out_data.pending_valid,
                                    want_result.pending_valid);
                if (out_data.candidate_len !== want_result.candidate_len)
                    report_mismatch("candidate_len", out_data.candidate_len,
                                    want_result.candidate_len);
                if (out_data.candidate_first !== want_result.candidate_first)
                    report_mismatch("candidate_first", out_data.candidate_first,
                                    want_result.candidate_first);
                if (out_data.candidate_second !== want_result.candidate_second)
                    report_mismatch("candidate_second", out_data.candidate_second,
                                    want_result.candidate_second);
                if (out_data.entry_mode !== want_result.entry_mode)
                    report_mismatch("entry_mode", out_data.entry_mode, want_result.entry_mode);
                if (out_data.read_data !== want_result.read_data)
                    report_mismatch("read_data", out_data.read_data, want_result.read_data);
            end
        end
    end

    // Hard stop if the run hangs
    initial
    begin
        #(WATCHDOG_NS);
        $display("Timeout: %0d result beats still outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        // Directed events, walked in order under the reset timeout
        directed_rows.push_back('{make_event(OP_READ, 8'h00, 32'd0, 8'h00), 1'b1,
            make_result(1'b0, 9'd0, 1'b0, 2'd0, 8'h00, 8'h00, MODE_LOWER, 8'h00)});
        directed_rows.push_back('{make_event(OP_SPARE_7, 8'hFF, 32'hFFFF_FFFF, 8'hFF), 1'b1,
            make_result(1'b0, 9'd0, 1'b0, 2'd0, 8'h00, 8'h00, MODE_LOWER, 8'h00)});
        directed_rows.push_back('{make_event(OP_BKSP, 8'h00, 32'd0, 8'h00), 1'b1,
            make_result(1'b0, 9'd0, 1'b0, 2'd0, 8'h00, 8'h00, MODE_LOWER, 8'h00)});
        directed_rows.push_back('{make_event(OP_KEY, KEY_0 - 8'd1, 32'd50, 8'h00), 1'b1,
            make_result(1'b0, 9'd0, 1'b0, 2'd0, 8'h00, 8'h00, MODE_LOWER, 8'h00)});
        directed_rows.push_back('{make_event(OP_KEY, KEY_0 + 8'd2, 32'd100, 8'h00), 1'b1,
            make_result(1'b1, 9'd0, 1'b1, 2'd1, LOWER_A, 8'h00, MODE_LOWER, 8'h00)});
        // step key 2 up to its accented glyph
        for (int t = 2; t <= 5; t++)
            directed_rows.push_back('{make_event(OP_KEY, KEY_0 + 8'd2, t * 100, 8'h00), 1'b0, '0});
        // tick one short of the timeout, then exactly on it
        directed_rows.push_back('{make_event(OP_TICK, 8'h00, 32'd1499, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_event(OP_TICK, 8'h00, 32'd1500, 8'h00), 1'b0, '0});
        // upper case accented glyph
        directed_rows.push_back('{make_event(OP_MODE, 8'h00, 32'd1500, 8'h00), 1'b0, '0});
        for (int t = 0; t < 5; t++)
            directed_rows.push_back('{make_event(OP_KEY, KEY_0 + 8'd2, 2000 + t * 100, 8'h00),
                                      1'b0, '0});
        // a new key commits; the same key after a full timeout commits too
        directed_rows.push_back('{make_event(OP_KEY, KEY_9, 32'd2500, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_event(OP_KEY, KEY_9, 32'd3500, 8'h00), 1'b0, '0});
        // cancel the pending glyph, then remove one byte and one two-byte glyph
        repeat (3)
            directed_rows.push_back('{make_event(OP_BKSP, 8'h00, 32'd3600, 8'h00), 1'b0, '0});
        // number mode appends the digit, then read it back
        directed_rows.push_back('{make_event(OP_MODE, 8'h00, 32'd3700, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_event(OP_KEY, KEY_0, 32'd3800, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_event(OP_READ, 8'h00, 32'd3900, 8'd2), 1'b0, '0});
        // same-key taps across the wrap of the millisecond counter
        directed_rows.push_back('{make_event(OP_MODE, 8'h00, 32'd4000, 8'h00), 1'b0, '0});
        directed_rows.push_back('{make_event(OP_KEY, KEY_0 + 8'd5, 32'hFFFF_FFF0, 8'h00),
                                  1'b0, '0});
        directed_rows.push_back('{make_event(OP_KEY, KEY_0 + 8'd5, 32'h0000_0010, 8'h00),
                                  1'b0, '0});
        directed_rows.push_back('{make_event(OP_CLEAR, 8'h00, 32'h0000_0020, 8'h00), 1'b1,
            make_result(1'b1, 9'd0, 1'b0, 2'd0, 8'h00, 8'h00, MODE_LOWER, 8'h00)});

        // Reset once
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_event(directed_rows[i].ev, directed_rows[i].has_fixed,
                       directed_rows[i].fixed_result);

        // Random traffic over several timeout settings
        wall_ms = 32'h0000_1000;
        type_for(PHASE_ITEMS);
        write_timeout(32'd0);
        type_for(PHASE_ITEMS);
        write_timeout(32'hFFFF_FFFF);
        no_idle = 1'b1;
        type_for(PHASE_ITEMS);
        no_idle = 1'b0;
        write_timeout(32'd1);
        type_for(PHASE_ITEMS);
        write_timeout($urandom_range(50, 5000));
        type_for(PHASE_ITEMS);
        write_timeout(32'd1000);
        type_for(PHASE_ITEMS);

        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
